// ===== hw/rtl/scale2x_pixel_upscaler_core_assert.svh =====
// ---------------------------------------------------------------------------
// scale2x upscaler assertion macros
// shared concurrent checks, clocked on clk and held off during rst
// ---------------------------------------------------------------------------
`ifndef SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH
`define SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define SCL2X_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scale2x invariant violated");

// antecedent at one edge implies consequent at the next edge
`define SCL2X_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scale2x sequence violated");

`endif

// ===== hw/rtl/scl2x_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scale2x upscaler package
// widths, register indexes, reset values and the scale2x block rule
// ---------------------------------------------------------------------------
package scl2x_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 32;

  // fixed port widths
  localparam int OUT_PIX_BITS   = 32;
  localparam int ROW_BITS       = 12;
  localparam int COL_BITS       = 10;
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 12;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  // register reset values
  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 11'd320;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 12'd240;

  typedef logic [OUT_PIX_BITS-1:0] pix_t;

  // neighbourhood of one source pixel
  typedef struct packed {
    pix_t b;
    pix_t d;
    pix_t e;
    pix_t f;
    pix_t h;
  } nbhd_t;

  // one 2x2 output block
  typedef struct packed {
    pix_t e0;
    pix_t e1;
    pix_t e2;
    pix_t e3;
  } quad_t;

  // scale2x rule, equality compares only
  function automatic quad_t scale_block(input nbhd_t n);
    quad_t q;
    q.e0 = n.e;
    q.e1 = n.e;
    q.e2 = n.e;
    q.e3 = n.e;
    if ((n.b != n.h) && (n.d != n.f)) begin
      q.e0 = (n.d == n.b) ? n.d : n.e;
      q.e1 = (n.b == n.f) ? n.f : n.e;
      q.e2 = (n.d == n.h) ? n.d : n.e;
      q.e3 = (n.h == n.f) ? n.f : n.e;
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/scale2x_pixel_upscaler_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scale2x pixel upscaler core
// raster pixel stream in, one 2x2 block per source pixel out, two row stores
// ---------------------------------------------------------------------------
//
//  channel  signals                          width  carries
//  -------  -------------------------------  -----  ---------------------------
//  cfg      cfg_write cfg_index cfg_data     1/1/12 frame_width, frame_height
//  in       in_valid in_ready pixel          32     source pixel, raster order
//  out      out_valid out_ready top_left ..  32x4   block, row/col, run flags
//
//  rows before the last: one item per cycle while the output is not stalled, one block per item (none on row 0)
//  last row: one block at column 0, two per item after that and three at row end;
//    the single output register takes one block at a time
//  an item is taken into the block stage, and its block is loaded from there into the output register
//  reset clears control, window and counters and sets the config registers; row stores are not cleared
//  a stalled output holds the block; the input stage then fills and in_ready drops
//
module scale2x_pixel_upscaler_core #(
  parameter int MAX_WIDTH  = scl2x_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = scl2x_pkg::DEF_PIXEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [scl2x_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [scl2x_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [scl2x_pkg::OUT_PIX_BITS-1:0]   pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [scl2x_pkg::OUT_PIX_BITS-1:0]   top_left,
  output logic [scl2x_pkg::OUT_PIX_BITS-1:0]   top_right,
  output logic [scl2x_pkg::OUT_PIX_BITS-1:0]   bottom_left,
  output logic [scl2x_pkg::OUT_PIX_BITS-1:0]   bottom_right,
  output logic [scl2x_pkg::ROW_BITS-1:0]       source_row,
  output logic [scl2x_pkg::COL_BITS-1:0]       source_col,
  output logic                                 last_of_run,
  output logic                                 frame_done
);
  import scl2x_pkg::*;

  `include "scale2x_pixel_upscaler_core_assert.svh"

  localparam int AW = $clog2(MAX_WIDTH);

  // pending block slots of one item
  localparam int BLK_ABOVE = 0;  // block of the pixel above, finished now
  localparam int BLK_LEFT  = 1;  // last row, block of the left neighbour
  localparam int BLK_SELF  = 2;  // last row, last column, own block

  typedef logic [PIXEL_BITS-1:0] spix_t;
  typedef logic [AW-1:0]         addr_t;

  // configuration registers
  logic [FW_BITS-1:0]  frame_width;
  logic [FH_BITS-1:0]  frame_height;

  // position and window
  addr_t               col_count;
  logic [ROW_BITS-1:0] row_count;
  spix_t               window_left;
  spix_t               window_centre;

  // row stores and their read data
  spix_t               older_mem [MAX_WIDTH];
  spix_t               newer_mem [MAX_WIDTH];
  spix_t               o0q;
  spix_t               o1q;
  spix_t               n0q;
  spix_t               n1q;

  // forwarding of the write that lands with the read
  logic                f_o0;
  logic                f_o1;
  logic                f_n0;
  logic                f_n1;
  spix_t               fwd_old;
  spix_t               fwd_new;

  // item in the block stage
  logic                s_valid;
  spix_t               s_pixel;
  addr_t               s_c;
  logic [ROW_BITS-1:0] s_r;
  logic [2:0]          s_pend;
  logic                s_edge;

  // accept side
  logic                acc;
  addr_t               wm1;
  logic [ROW_BITS-1:0] hm1;
  addr_t               c_a;
  logic [ROW_BITS-1:0] r_a;
  logic                last_a;
  spix_t               in_pix;

  // block side
  spix_t               above;
  spix_t               above_old;
  spix_t               left_old;
  spix_t               n1v;
  spix_t               right;
  logic [2:0]          em;
  logic [2:0]          pend_after;
  logic                out_load;
  logic                s_fire;
  logic                ex_rd;
  nbhd_t               nb;
  quad_t               blk;
  logic [ROW_BITS-1:0] blk_row;
  addr_t               blk_col;
  logic                blk_done;

  // effective frame limits
  always_comb begin
    if (frame_width < FW_BITS'(2)) begin
      wm1 = AW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(frame_width - FW_BITS'(1));
    end
    if (frame_height < FH_BITS'(2)) begin
      hm1 = ROW_BITS'(1);
    end else begin
      hm1 = frame_height - FH_BITS'(1);
    end
  end

  // clamped position of the incoming item
  assign c_a    = (col_count > wm1) ? wm1 : col_count;
  assign r_a    = (row_count > hm1) ? hm1 : row_count;
  assign last_a = (r_a == hm1);
  assign in_pix = pixel[PIXEL_BITS-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stored values with forwarding applied
  assign above     = f_n0 ? fwd_new : n0q;
  assign above_old = f_o0 ? fwd_old : o0q;
  assign left_old  = f_o1 ? fwd_old : o1q;
  assign n1v       = f_n1 ? fwd_new : n1q;
  assign right     = s_edge ? above : n1v;

  // pick the next pending block
  always_comb begin
    em = 3'b000;
    if (s_pend[BLK_ABOVE]) begin
      em[BLK_ABOVE] = 1'b1;
    end else if (s_pend[BLK_LEFT]) begin
      em[BLK_LEFT] = 1'b1;
    end else if (s_pend[BLK_SELF]) begin
      em[BLK_SELF] = 1'b1;
    end
  end

  assign pend_after = s_pend & ~em;
  assign out_load   = s_valid && (s_pend != 3'b000) && (!out_valid || out_ready);
  assign s_fire     = s_valid && ((s_pend == 3'b000) ||
                                  (out_load && (pend_after == 3'b000)));
  // second read of the newer store for the left block, two columns back
  assign ex_rd      = out_load && em[BLK_ABOVE] && s_pend[BLK_LEFT] &&
                      (s_c > AW'(1));
  assign in_ready   = !rst && (!s_valid || s_fire);
  assign acc        = in_valid && in_ready;

  // neighbourhood of the selected block
  always_comb begin
    nb       = '0;
    blk_row  = s_r;
    blk_col  = s_c;
    blk_done = 1'b0;
    case (1'b1)
      em[BLK_ABOVE]: begin
        nb.b    = OUT_PIX_BITS'((s_r > ROW_BITS'(1)) ? above_old : above);
        nb.d    = OUT_PIX_BITS'((s_c != '0) ? window_left : above);
        nb.e    = OUT_PIX_BITS'(above);
        nb.f    = OUT_PIX_BITS'(right);
        nb.h    = OUT_PIX_BITS'(s_pixel);
        blk_row = s_r - ROW_BITS'(1);
      end
      em[BLK_LEFT]: begin
        nb.b    = OUT_PIX_BITS'(left_old);
        nb.d    = OUT_PIX_BITS'((s_c > AW'(1)) ? n1q : window_centre);
        nb.e    = OUT_PIX_BITS'(window_centre);
        nb.f    = OUT_PIX_BITS'(s_pixel);
        nb.h    = OUT_PIX_BITS'(window_centre);
        blk_col = s_c - AW'(1);
      end
      em[BLK_SELF]: begin
        nb.b     = OUT_PIX_BITS'(above);
        nb.d     = OUT_PIX_BITS'(window_centre);
        nb.e     = OUT_PIX_BITS'(s_pixel);
        nb.f     = OUT_PIX_BITS'(s_pixel);
        nb.h     = OUT_PIX_BITS'(s_pixel);
        blk_done = 1'b1;
      end
      default: ;
    endcase
  end

  assign blk = scale_block(nb);

  // older row store: write on retire, two reads on accept
  always_ff @(posedge clk) begin
    if (s_fire) begin
      older_mem[s_c] <= above;
    end
    if (acc) begin
      o0q <= older_mem[c_a];
      o1q <= older_mem[c_a - AW'(1)];
    end
  end

  // newer row store: write on retire, two reads on accept, one late read
  always_ff @(posedge clk) begin
    if (s_fire) begin
      newer_mem[s_c] <= s_pixel;
    end
    if (acc) begin
      n0q <= newer_mem[c_a];
      n1q <= newer_mem[c_a + AW'(1)];
    end else if (ex_rd) begin
      n1q <= newer_mem[s_c - AW'(2)];
    end
  end

  // forwarding flags for a retire that meets the read
  always_ff @(posedge clk) begin
    if (rst) begin
      f_o0 <= 1'b0;
      f_o1 <= 1'b0;
      f_n0 <= 1'b0;
      f_n1 <= 1'b0;
    end else if (acc) begin
      f_o0 <= s_fire && (s_c == c_a);
      f_o1 <= s_fire && (s_c == c_a - AW'(1));
      f_n0 <= s_fire && (s_c == c_a);
      f_n1 <= s_fire && (s_c == c_a + AW'(1));
    end else if (ex_rd) begin
      f_n1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_old <= above;
      fwd_new <= s_pixel;
    end
  end

  // block stage control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_pend  <= 3'b000;
    end else if (acc) begin
      s_valid         <= 1'b1;
      s_pend[BLK_ABOVE] <= (r_a != '0);
      s_pend[BLK_LEFT]  <= last_a && (c_a != '0);
      s_pend[BLK_SELF]  <= last_a && (c_a == wm1);
    end else if (s_fire) begin
      s_valid <= 1'b0;
      s_pend  <= 3'b000;
    end else if (out_load) begin
      s_pend <= pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_pixel <= in_pix;
      s_c     <= c_a;
      s_r     <= r_a;
      s_edge  <= (c_a == wm1);
    end
  end

  // position counters advance on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (c_a == wm1) begin
        col_count <= '0;
        row_count <= last_a ? '0 : r_a + ROW_BITS'(1);
      end else begin
        col_count <= c_a + AW'(1);
        row_count <= r_a;
      end
    end
  end

  // window registers update when the item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= '0;
      window_centre <= '0;
    end else if (s_fire) begin
      window_left   <= above;
      window_centre <= s_pixel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_left     <= blk.e0;
      top_right    <= blk.e1;
      bottom_left  <= blk.e2;
      bottom_right <= blk.e3;
      source_row   <= blk_row;
      source_col   <= COL_BITS'(blk_col);
      last_of_run  <= (pend_after == 3'b000);
      frame_done   <= blk_done;
    end
  end

  // checks
  `SCL2X_ASSERT_HOLD(a_late_read_no_accept, !(ex_rd && acc))
  `SCL2X_ASSERT_HOLD(a_late_read_left_pending, !ex_rd || s_pend[BLK_LEFT])
  `SCL2X_ASSERT_HOLD(a_done_is_last, !(out_valid && frame_done) || last_of_run)
  `SCL2X_ASSERT_NEXT(a_accept_fills_stage, acc, s_valid)

endmodule
